// ===== hdl/cdn_pkg.sv =====
// Shared types, microcode codes and calendar helpers for the date normaliser.
// No dependencies; imported by every other file in hdl/.
package cdn_pkg;

  localparam int unsigned DayW   = 21;
  localparam int unsigned MonW   = 13;
  localparam int unsigned YearW  = 15;
  localparam int unsigned StepW  = 3;
  localparam int unsigned LenW   = 5;

  localparam logic [MonW-1:0]  MonthsPerYear = MonW'(12);
  localparam logic [YearW-1:0] LeapCycle     = YearW'(400);
  localparam logic [YearW-1:0] LastInCycle   = YearW'(399);

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepIdle   = 3'd0;
  localparam step_t StepMonth  = 3'd1;
  localparam step_t StepCopy   = 3'd2;
  localparam step_t StepCycle  = 3'd3;
  localparam step_t StepSettle = 3'd4;
  localparam step_t StepEmit   = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MSUB,
    OP_RCOPY,
    OP_RSUB,
    OP_MSTEP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NOT_ACC,
    C_M_LE12,
    C_R_LT400,
    C_D_FITS,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    cond_e cond;
    op_e   op;
    step_t jmp;
    step_t nxt;
  } uword_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic m_le12;
    logic r_lt400;
    logic d_fits;
    logic out_busy;
  } status_t;

  // r is the year modulo 400
  function automatic logic is_leap(input logic [YearW-1:0] r);
    logic div4;
    logic cent;
    div4 = (r[1:0] == 2'd0);
    cent = (r == YearW'(100)) || (r == YearW'(200)) || (r == YearW'(300));
    return (r == '0) || (div4 && !cent);
  endfunction

  function automatic logic [LenW-1:0] month_len(input logic [3:0] m, input logic leap);
    logic [LenW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LenW'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = LenW'(30);
      4'd2:                                       len = leap ? LenW'(29) : LenW'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/cdn_sequencer.sv =====
// Microcode sequencer: step counter, control store and branch conditions.
// Depends on cdn_pkg.
module cdn_sequencer import cdn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  step_t  step_q, step_d;
  uword_t word;
  logic   take;

  always_comb begin
    unique case (step_q)
      StepIdle:   word = '{cond: C_NOT_ACC,  op: OP_LOAD,  jmp: StepIdle,   nxt: StepMonth};
      StepMonth:  word = '{cond: C_M_LE12,   op: OP_MSUB,  jmp: StepCopy,   nxt: StepMonth};
      StepCopy:   word = '{cond: C_NEVER,    op: OP_RCOPY, jmp: StepCycle,  nxt: StepCycle};
      StepCycle:  word = '{cond: C_R_LT400,  op: OP_RSUB,  jmp: StepSettle, nxt: StepCycle};
      StepSettle: word = '{cond: C_D_FITS,   op: OP_MSTEP, jmp: StepEmit,   nxt: StepSettle};
      StepEmit:   word = '{cond: C_OUT_BUSY, op: OP_EMIT,  jmp: StepEmit,   nxt: StepIdle};
      default:    word = '{cond: C_NEVER,    op: OP_NONE,  jmp: StepIdle,   nxt: StepIdle};
    endcase
  end

  assign in_ready_o = (step_q == StepIdle);

  always_comb begin
    unique case (word.cond)
      C_NEVER:    take = 1'b0;
      C_NOT_ACC:  take = !in_valid_i;
      C_M_LE12:   take = status_i.m_le12;
      C_R_LT400:  take = status_i.r_lt400;
      C_D_FITS:   take = status_i.d_fits;
      C_OUT_BUSY: take = status_i.out_busy;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      step_d    = word.jmp;
      ctrl_o.op = OP_NONE;
    end else begin
      step_d    = word.nxt;
      ctrl_o.op = word.op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== hdl/cdn_datapath.sv =====
// Datapath: day/month/year/cycle registers, month-length lookup, output register.
// Depends on cdn_pkg; driven by cdn_sequencer.
module cdn_datapath import cdn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  output status_t                 status_o,
  input  logic                    cmd_i,
  input  logic signed [DayW-1:0]  day_in_i,
  input  logic signed [MonW-1:0]  month_in_i,
  input  logic signed [YearW-1:0] year_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [4:0]              day_out_o,
  output logic [3:0]              month_out_o,
  output logic [YearW-1:0]        year_out_o
);

  logic [DayW-1:0]  d_q, d_d;
  logic [MonW-1:0]  m_q, m_d;
  logic [YearW-1:0] y_q, y_d;
  logic [YearW-1:0] r_q, r_d;
  logic             ov_q, ov_d;
  logic [4:0]       od_q;
  logic [3:0]       om_q;
  logic [YearW-1:0] oy_q;

  logic [DayW-1:0]  d_mag;
  logic [MonW-1:0]  m_mag;
  logic [YearW-1:0] y_mag;
  logic [LenW-1:0]  len;

  assign d_mag = day_in_i[DayW-1]    ? DayW'(~day_in_i + 1'b1)    : DayW'(day_in_i);
  assign m_mag = month_in_i[MonW-1]  ? MonW'(~month_in_i + 1'b1)  : MonW'(month_in_i);
  assign y_mag = year_in_i[YearW-1]  ? YearW'(~year_in_i + 1'b1)  : YearW'(year_in_i);

  assign len = month_len(m_q[3:0], is_leap(r_q));

  assign status_o.m_le12   = (m_q <= MonthsPerYear);
  assign status_o.r_lt400  = (r_q < LeapCycle);
  assign status_o.d_fits   = (d_q <= DayW'(len));
  assign status_o.out_busy = ov_q && !out_ready_i;

  always_comb begin
    d_d  = d_q;
    m_d  = m_q;
    y_d  = y_q;
    r_d  = r_q;
    ov_d = ov_q && !out_ready_i;
    unique case (ctrl_i.op)
      OP_LOAD: begin
        if (cmd_i) begin
          d_d = d_mag;
          m_d = (m_mag == '0) ? MonW'(1) : m_mag;
          y_d = y_mag;
        end else begin
          d_d = (d_mag == '0) ? DayW'(1) : d_mag;
          m_d = MonW'(1);
          y_d = YearW'(1);
        end
      end
      OP_MSUB: begin
        m_d = m_q - MonthsPerYear;
        y_d = y_q + 1'b1;
      end
      OP_RCOPY: r_d = y_q;
      OP_RSUB:  r_d = r_q - LeapCycle;
      OP_MSTEP: begin
        d_d = d_q - DayW'(len);
        if (m_q == MonthsPerYear) begin
          m_d = MonW'(1);
          y_d = y_q + 1'b1;
          r_d = (r_q == LastInCycle) ? '0 : r_q + 1'b1;
        end else begin
          m_d = m_q + 1'b1;
        end
      end
      OP_EMIT:  ov_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    m_q <= m_d;
    y_q <= y_d;
    r_q <= r_d;
    if (ctrl_i.op == OP_EMIT) begin
      od_q <= d_q[4:0];
      om_q <= m_q[3:0];
      oy_q <= y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign day_out_o   = od_q;
  assign month_out_o = om_q;
  assign year_out_o  = oy_q;

endmodule

// ===== hdl/calendar_date_normalizer_unit.sv =====
// Gregorian date normaliser, top level; built from cdn_pkg, cdn_sequencer, cdn_datapath.
// After acceptance the sequencer carries whole years out of the month, reduces the year modulo
// 400 and walks months off the day value, then emits; a new word is accepted only once the
// previous one is emitted, and an output stall holds the emit step.
// A finished date waits in the output register while the next word is accepted.
// Async active-low reset: sequencer back to idle, output register empty.
module calendar_date_normalizer_unit import cdn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic signed [DayW-1:0]  day_in_i,
  input  logic signed [MonW-1:0]  month_in_i,
  input  logic signed [YearW-1:0] year_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [4:0]              day_out_o,
  output logic [3:0]              month_out_o,
  output logic [YearW-1:0]        year_out_o
);

  ctrl_t   ctrl;
  status_t status;

  cdn_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  cdn_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .cmd_i       (cmd_i),
    .day_in_i    (day_in_i),
    .month_in_i  (month_in_i),
    .year_in_i   (year_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .day_out_o   (day_out_o),
    .month_out_o (month_out_o),
    .year_out_o  (year_out_o)
  );

endmodule

// ===== tb/sv/cdn_tb_pkg.sv =====
`timescale 1ns / 1ps
// Command codes shared by the date normaliser testbench and its checker.
// No dependencies.
package cdn_tb_pkg;

  typedef enum logic {
    CMD_COUNT     = 1'b0,
    CMD_NORMALISE = 1'b1
  } date_cmd_e;

endpackage

// ===== tb/sv/cdn_date_checker.sv =====
`timescale 1ns / 1ps
// Checker for the date normaliser: watches both channels, predicts each date
// and compares it with the one returned. Depends on cdn_pkg and cdn_tb_pkg.
module cdn_date_checker import cdn_pkg::*; import cdn_tb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    cmd_i,
  input  logic signed [DayW-1:0]  day_in_i,
  input  logic signed [MonW-1:0]  month_in_i,
  input  logic signed [YearW-1:0] year_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [4:0]              day_out_i,
  input  logic [3:0]              month_out_i,
  input  logic [YearW-1:0]        year_out_i,
  output int unsigned             pending_o,
  output int unsigned             errors_o
);

  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [YearW-1:0] year;
  } cal_date_t;

  cal_date_t   date_q[$];
  int unsigned reported;

  function automatic int unsigned magn(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      2:          return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic cal_date_t normalise_date(input date_cmd_e cmd, input int d_raw,
                                               input int m_raw, input int y_raw);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    cal_date_t   r;
    d = magn(d_raw);
    if (cmd == CMD_COUNT) begin
      m = 1;
      y = 1;
      if (d == 0) d = 1;
    end else begin
      m = magn(m_raw);
      y = magn(y_raw);
      if (m == 0) begin
        m = 1;
      end else begin
        y += (m - 1) / 12;
        m = (m - 1) % 12 + 1;
      end
    end
    while (d > month_days(m, y)) begin
      d -= month_days(m, y);
      m++;
      if (m > 12) begin
        m = 1;
        y++;
      end
    end
    r.day   = d[4:0];
    r.month = m[3:0];
    r.year  = y[YearW-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin : monitor
    cal_date_t want;
    cal_date_t got;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got = '{day: day_out_i, month: month_out_i, year: year_out_i};
        if (date_q.size() == 0) begin
          errors_o++;
          if (reported < ReportMax) begin
            reported++;
            $display("unexpected word: %0d/%0d/%0d", got.day, got.month, got.year);
          end
        end else begin
          want = date_q.pop_front();
          if (got.day !== want.day || got.month !== want.month || got.year !== want.year)
          begin
            errors_o++;
            if (reported < ReportMax) begin
              reported++;
              $display("date mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       want.day, want.month, want.year, got.day, got.month, got.year);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i)
        date_q.push_back(normalise_date(date_cmd_e'(cmd_i), int'(day_in_i),
                                        int'(month_in_i), int'(year_in_i)));
      pending_o = date_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_calendar_date_normalizer_unit.sv =====
`timescale 1ns / 1ps
// Top of the date normaliser testbench: clock, reset, directed and random words,
// back-pressure phases and verdict. Depends on cdn_pkg, cdn_tb_pkg, cdn_date_checker.
module tb_calendar_date_normalizer_unit;
  import cdn_pkg::*;
  import cdn_tb_pkg::*;

  localparam int unsigned CycleLimit  = 4000000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandWords   = 80;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    cmd;
  logic signed [DayW-1:0]  day_in;
  logic signed [MonW-1:0]  month_in;
  logic signed [YearW-1:0] year_in;
  logic                    out_valid;
  logic                    out_ready;
  logic [4:0]              day_out;
  logic [3:0]              month_out;
  logic [YearW-1:0]        year_out;

  int unsigned pending;
  int unsigned errors;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned big_left;
  int unsigned cycle_cnt;

  calendar_date_normalizer_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .day_in_i    (day_in),
    .month_in_i  (month_in),
    .year_in_i   (year_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .day_out_o   (day_out),
    .month_out_o (month_out),
    .year_out_o  (year_out)
  );

  cdn_date_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .cmd_i       (cmd),
    .day_in_i    (day_in),
    .month_in_i  (month_in),
    .year_in_i   (year_in),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .day_out_i   (day_out),
    .month_out_i (month_out),
    .year_out_i  (year_out),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input date_cmd_e c, input int d, input int m, input int y);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd      = c;
    day_in   = d[DayW-1:0];
    month_in = m[MonW-1:0];
    year_in  = y[YearW-1:0];
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    date_cmd_e   c;
    int          d;
    int          m;
    int          y;
    int unsigned sel;
    c   = date_cmd_e'($urandom_range(1));
    sel = $urandom_range(99);
    if (sel < 4 && big_left > 0) begin
      big_left--;
      d = int'($urandom_range(2097151)) - 1048576;
      m = int'($urandom_range(8191)) - 4096;
      y = int'($urandom_range(32767)) - 16384;
    end else if (sel < 40) begin
      d = $urandom_range(32);
      m = $urandom_range(13);
      y = $urandom_range(2400);
    end else begin
      d = $urandom_range(1500);
      if ($urandom_range(1)) d = -d;
      m = int'($urandom_range(8191)) - 4096;
      y = int'($urandom_range(32767)) - 16384;
    end
    send_word(c, d, m, y);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    cmd          = CMD_COUNT;
    day_in       = '0;
    month_in     = '0;
    year_in      = '0;
    src_idle_pct = 11;
    snk_idle_pct = 64;
    big_left     = 6;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // day counts: zero, month and year edges, extremes
    send_word(CMD_COUNT, 0, 5, 7);
    send_word(CMD_COUNT, 1, 0, 0);
    send_word(CMD_COUNT, 31, 0, 0);
    send_word(CMD_COUNT, 32, 0, 0);
    send_word(CMD_COUNT, 365, 0, 0);
    send_word(CMD_COUNT, -366, -1, -1);
    send_word(CMD_COUNT, 1048575, 4095, 16383);
    send_word(CMD_COUNT, -1048576, -4096, -16384);
    // normalise: zero fields, leap rules, month carry, extremes
    send_word(CMD_NORMALISE, 0, 0, 0);
    send_word(CMD_NORMALISE, 29, 2, 0);
    send_word(CMD_NORMALISE, 29, 2, 1900);
    send_word(CMD_NORMALISE, 29, 2, 2000);
    send_word(CMD_NORMALISE, 30, 2, 2024);
    send_word(CMD_NORMALISE, 31, 12, 5);
    send_word(CMD_NORMALISE, 1, 24, 5);
    send_word(CMD_NORMALISE, 1, 13, 5);
    send_word(CMD_NORMALISE, 0, 14, 7);
    send_word(CMD_NORMALISE, -31, -1, -1);
    send_word(CMD_NORMALISE, 366, 1, 2023);
    send_word(CMD_NORMALISE, 32, 0, 3);
    send_word(CMD_NORMALISE, 1048575, 4095, 16383);
    send_word(CMD_NORMALISE, -1048576, -4096, -16384);

    for (int i = 0; i < RandWords; i++) begin
      if (i == RandWords / 3) begin
        src_idle_pct = 64;
        snk_idle_pct = 11;
      end else if (i == 2 * RandWords / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      send_random();
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
